// ----- design/dbc_pkg.sv -----
// shared types, constants and a helper function for the disk request bounds check unit
// no dependencies
`default_nettype none

package dbc_pkg;

    localparam int SLICES          = 4;
    localparam int PARTITIONS      = 8;
    localparam int LABEL_SECTOR    = 1;
    localparam int LABEL_PARTITION = 0;
    localparam int BLOCK_SHIFT     = 9;
    localparam int PART_ENTRIES    = SLICES * PARTITIONS;
    localparam int PIDX_W          = $clog2(PART_ENTRIES);
    localparam int DIV_STEPS       = 31;

    localparam logic [1:0] KIND_REQUEST    = 2'd0;
    localparam logic [1:0] KIND_LOAD_SLICE = 2'd1;
    localparam logic [1:0] KIND_LOAD_PART  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EOF     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_ROFS    = 2'd3;

    typedef struct packed {
        logic        load;
        logic        bad;
        logic        wr;
        logic        wlabel;
        logic        labelled;
        logic [31:0] soff;
        logic [31:0] endsec;
        logic [31:0] poff;
        logic [31:0] lab;
        logic [23:0] count;
    } dbc_side_t;

    typedef struct packed {
        logic        valid;
        dbc_side_t   side;
        logic [30:0] qa;
        logic [7:0]  ra;
        logic [30:0] qb;
        logic [7:0]  rb;
    } dbc_div_out_t;

    // one restoring divide step: returns {remainder, shifted dividend/quotient}
    function automatic logic [38:0] div_step(input logic [7:0] rem, input logic [30:0] dq,
                                             input logic [7:0] m);
        logic [8:0] trial;
        logic       ge;
        logic [7:0] rem_new;
        trial   = {rem, dq[30]};
        ge      = (trial >= {1'b0, m});
        rem_new = ge ? 8'(trial - {1'b0, m}) : trial[7:0];
        return {rem_new, dq[29:0], ge};
    endfunction

endpackage

`default_nettype wire

// ----- design/dbc_tables.sv -----
// slice and partition table storage, written by load items and read by requests
// depends on dbc_pkg
`default_nettype none

module dbc_tables (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  kind,
    input  wire logic [1:0]  slice_index,
    input  wire logic [2:0]  partition_index,
    input  wire logic [31:0] entry_offset,
    input  wire logic [31:0] entry_size,
    input  wire logic        entry_write_label,
    input  wire logic        entry_label_valid,
    output logic [31:0]      rd_soff,
    output logic [31:0]      rd_ssize,
    output logic             rd_wlabel,
    output logic             rd_labelled,
    output logic [31:0]      rd_poff,
    output logic [31:0]      rd_psize,
    output logic [31:0]      rd_lab
);

    logic [31:0] soff_reg   [dbc_pkg::SLICES];
    logic [31:0] ssize_reg  [dbc_pkg::SLICES];
    logic        wlabel_reg [dbc_pkg::SLICES];
    logic        lvalid_reg [dbc_pkg::SLICES];
    logic [31:0] lab_reg    [dbc_pkg::SLICES];
    logic [31:0] poff_reg   [dbc_pkg::PART_ENTRIES];
    logic [31:0] psize_reg  [dbc_pkg::PART_ENTRIES];

    logic                      slice_ok;
    logic                      part_ok;
    logic [dbc_pkg::PIDX_W-1:0] pidx;

    assign slice_ok = (32'(slice_index) < dbc_pkg::SLICES);
    assign part_ok  = (32'(partition_index) < dbc_pkg::PARTITIONS);
    assign pidx     = dbc_pkg::PIDX_W'(32'(slice_index) * dbc_pkg::PARTITIONS
                                       + 32'(partition_index));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dbc_pkg::SLICES; i++)
            begin
                soff_reg[i]   <= '0;
                ssize_reg[i]  <= '0;
                wlabel_reg[i] <= 1'b0;
                lvalid_reg[i] <= 1'b0;
                lab_reg[i]    <= '0;
            end
            for (int j = 0; j < dbc_pkg::PART_ENTRIES; j++)
            begin
                poff_reg[j]  <= '0;
                psize_reg[j] <= '0;
            end
        end
        else if (accept && slice_ok)
        begin
            if (kind == dbc_pkg::KIND_LOAD_SLICE)
            begin
                soff_reg[slice_index]   <= entry_offset;
                ssize_reg[slice_index]  <= entry_size;
                wlabel_reg[slice_index] <= entry_write_label;
                lvalid_reg[slice_index] <= entry_label_valid;
            end
            else if (kind == dbc_pkg::KIND_LOAD_PART && part_ok)
            begin
                poff_reg[pidx]  <= entry_offset;
                psize_reg[pidx] <= entry_size;
                if (32'(partition_index) == dbc_pkg::LABEL_PARTITION)
                begin
                    lab_reg[slice_index] <= entry_offset;
                end
            end
        end
    end

    assign rd_soff     = soff_reg[slice_index];
    assign rd_ssize    = ssize_reg[slice_index];
    assign rd_wlabel   = wlabel_reg[slice_index];
    assign rd_labelled = lvalid_reg[slice_index];
    assign rd_lab      = lab_reg[slice_index];
    assign rd_poff     = poff_reg[pidx];
    assign rd_psize    = psize_reg[pidx];

endmodule

`default_nettype wire

// ----- design/dbc_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes sharing one divisor
// depends on dbc_pkg
`default_nettype none

module dbc_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_load,
    input  wire dbc_pkg::dbc_side_t side_in,
    input  wire logic [30:0]       dividend_a,
    input  wire logic [30:0]       dividend_b,
    input  wire logic [7:0]        divisor,
    output dbc_pkg::dbc_div_out_t  result
);

    localparam int N = dbc_pkg::DIV_STEPS;

    logic              valid_reg [N];
    dbc_pkg::dbc_side_t side_reg [N];
    logic [7:0]        ra_reg    [N];
    logic [30:0]       dqa_reg   [N];
    logic [7:0]        rb_reg    [N];
    logic [30:0]       dqb_reg   [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic              valid_prev;
        dbc_pkg::dbc_side_t side_prev;
        logic [7:0]        ra_prev;
        logic [30:0]       dqa_prev;
        logic [7:0]        rb_prev;
        logic [30:0]       dqb_prev;
        logic [38:0]       step_a;
        logic [38:0]       step_b;

        if (k == 0)
        begin : g_first
            assign valid_prev = in_load;
            assign side_prev  = side_in;
            assign ra_prev    = '0;
            assign dqa_prev   = dividend_a;
            assign rb_prev    = '0;
            assign dqb_prev   = dividend_b;
        end
        else
        begin : g_next
            assign valid_prev = valid_reg[k-1];
            assign side_prev  = side_reg[k-1];
            assign ra_prev    = ra_reg[k-1];
            assign dqa_prev   = dqa_reg[k-1];
            assign rb_prev    = rb_reg[k-1];
            assign dqb_prev   = dqb_reg[k-1];
        end

        assign step_a = dbc_pkg::div_step(ra_prev, dqa_prev, divisor);
        assign step_b = dbc_pkg::div_step(rb_prev, dqb_prev, divisor);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_prev;
                ra_reg[k]   <= step_a[38:31];
                dqa_reg[k]  <= step_a[30:0];
                rb_reg[k]   <= step_b[38:31];
                dqb_reg[k]  <= step_b[30:0];
            end
        end
    end

    assign result.valid = valid_reg[N-1];
    assign result.side  = side_reg[N-1];
    assign result.qa    = dqa_reg[N-1];
    assign result.ra    = ra_reg[N-1];
    assign result.qb    = dqb_reg[N-1];
    assign result.rb    = rb_reg[N-1];

endmodule

`default_nettype wire

// ----- design/dbc_check.sv -----
// bounds, label protection and truncation stages with the output register
// depends on dbc_pkg
`default_nettype none

module dbc_check (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [7:0]           mult,
    input  wire dbc_pkg::dbc_div_out_t div,
    output logic                      out_valid,
    output logic [1:0]                status,
    output logic [32:0]               physical_sector,
    output logic [23:0]               granted_bytes,
    output logic [23:0]               residual_bytes
);

    // first check stage
    logic        c1_valid_reg;
    logic        c1_load_reg;
    logic        c1_bad_reg;
    logic        c1_rofs_en_reg;
    logic [32:0] c1_rel_reg;
    logic [32:0] c1_prot_reg;
    logic [14:0] c1_nsec_reg;
    logic [31:0] c1_soff_reg;
    logic        c1_over_reg;
    logic        c1_eq_reg;
    logic        c1_gt_reg;
    logic [14:0] c1_diff_reg;
    logic [23:0] c1_count_reg;

    logic [30:0] secno;
    logic [14:0] nsec;
    logic [32:0] rel_next;
    logic [32:0] prot_next;
    logic [32:0] end_sum;

    assign secno     = div.qa;
    assign nsec      = div.qb[14:0];
    assign rel_next  = div.side.labelled ? (33'(div.side.poff) + 33'(secno)) : 33'(secno);
    assign prot_next = 33'(dbc_pkg::LABEL_SECTOR) + 33'(div.side.lab);
    assign end_sum   = 33'(secno) + 33'(nsec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= div.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_load_reg    <= div.side.load;
            c1_bad_reg     <= div.side.bad || (div.ra != 8'd0) || (div.rb != 8'd0);
            c1_rofs_en_reg <= div.side.wr && !div.side.wlabel && div.side.labelled;
            c1_rel_reg     <= rel_next;
            c1_prot_reg    <= prot_next;
            c1_nsec_reg    <= nsec;
            c1_soff_reg    <= div.side.soff;
            c1_over_reg    <= end_sum > 33'(div.side.endsec);
            c1_eq_reg      <= 32'(secno) == div.side.endsec;
            c1_gt_reg      <= 32'(secno) > div.side.endsec;
            c1_diff_reg    <= 15'(div.side.endsec - 32'(secno));
            c1_count_reg   <= div.side.count;
        end
    end

    // second check stage into the output register
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [32:0] phys_reg;
    logic [23:0] granted_reg;
    logic [23:0] resid_reg;

    logic [33:0] rel_end;
    logic        rofs;
    logic [22:0] prod;
    logic [23:0] trunc_bytes;
    logic [1:0]  status_next;
    logic [32:0] phys_next;
    logic [23:0] granted_next;
    logic [23:0] resid_next;

    assign rel_end     = 34'(c1_rel_reg) + 34'(c1_nsec_reg);
    assign rofs        = c1_rofs_en_reg && (c1_rel_reg <= c1_prot_reg)
                         && ((dbc_pkg::LABEL_SECTOR == 0) || (rel_end > 34'(c1_prot_reg)));
    assign prod        = 23'(c1_diff_reg) * 23'(mult);
    assign trunc_bytes = 24'({prod, 9'd0});

    always_comb
    begin
        status_next  = dbc_pkg::ST_OK;
        phys_next    = '0;
        granted_next = '0;
        resid_next   = c1_count_reg;
        priority if (c1_load_reg)
        begin
            resid_next = '0;
        end
        else if (c1_bad_reg)
        begin
            status_next = dbc_pkg::ST_INVALID;
        end
        else if (rofs)
        begin
            status_next = dbc_pkg::ST_ROFS;
        end
        else if (c1_over_reg && c1_eq_reg)
        begin
            status_next = dbc_pkg::ST_EOF;
        end
        else if (c1_over_reg && c1_gt_reg)
        begin
            status_next = dbc_pkg::ST_INVALID;
        end
        else
        begin
            phys_next    = 33'(c1_soff_reg) + c1_rel_reg;
            granted_next = c1_over_reg ? trunc_bytes : c1_count_reg;
            resid_next   = c1_count_reg - granted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg  <= status_next;
            phys_reg    <= phys_next;
            granted_reg <= granted_next;
            resid_reg   <= resid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign physical_sector = phys_reg;
    assign granted_bytes   = granted_reg;
    assign residual_bytes  = resid_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != dbc_pkg::ST_OK) |-> (granted_reg == '0)
                                                           && (phys_reg == '0))
        else $error("error item carries a grant or sector");

    a_eof_rofs_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((status_reg == dbc_pkg::ST_EOF) || (status_reg == dbc_pkg::ST_ROFS))
        |-> (resid_reg != '0))
        else $error("end of file or read-only item with empty residual");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && c1_valid_reg |=> out_valid_reg)
        else $error("item lost between check stage and output");

endmodule

`default_nettype wire

// ----- design/disk_request_bounds_check_unit.sv -----
// pipeline: 31 divider stages, then 2 check stages, from input accept to output valid
// throughput: one item per cycle; a stalled output freezes the whole pipeline in place
// reset: asynchronous active low; tables clear to zero, sector multiplier to 1, pipe empties
// top level of the disk request bounds check unit
// depends on dbc_pkg, dbc_tables, dbc_divider, dbc_check
`default_nettype none

module disk_request_bounds_check_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [1:0]  slice_index,
    input  wire logic [2:0]  partition_index,
    input  wire logic [31:0] block_number,
    input  wire logic [23:0] byte_count,
    input  wire logic        is_write,
    input  wire logic [31:0] entry_offset,
    input  wire logic [31:0] entry_size,
    input  wire logic        entry_write_label,
    input  wire logic        entry_label_valid,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [32:0]      physical_sector,
    output logic [23:0]      granted_bytes,
    output logic [23:0]      residual_bytes
);

    logic [7:0] mult_reg;
    logic       en;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            mult_reg <= cfg_wdata;
        end
    end

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;
    assign accept   = in_valid && en;

    logic [31:0] rd_soff;
    logic [31:0] rd_ssize;
    logic        rd_wlabel;
    logic        rd_labelled;
    logic [31:0] rd_poff;
    logic [31:0] rd_psize;
    logic [31:0] rd_lab;

    dbc_tables u_tables (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .kind              (kind),
        .slice_index       (slice_index),
        .partition_index   (partition_index),
        .entry_offset      (entry_offset),
        .entry_size        (entry_size),
        .entry_write_label (entry_write_label),
        .entry_label_valid (entry_label_valid),
        .rd_soff           (rd_soff),
        .rd_ssize          (rd_ssize),
        .rd_wlabel         (rd_wlabel),
        .rd_labelled       (rd_labelled),
        .rd_poff           (rd_poff),
        .rd_psize          (rd_psize),
        .rd_lab            (rd_lab)
    );

    dbc_pkg::dbc_side_t side;
    logic               is_load;
    logic               slice_ok;
    logic               part_ok;

    assign is_load  = (kind == dbc_pkg::KIND_LOAD_SLICE) || (kind == dbc_pkg::KIND_LOAD_PART);
    assign slice_ok = (32'(slice_index) < dbc_pkg::SLICES);
    assign part_ok  = (32'(partition_index) < dbc_pkg::PARTITIONS);

    always_comb
    begin
        side.load     = is_load;
        side.bad      = (kind != dbc_pkg::KIND_REQUEST) || !slice_ok || block_number[31]
                        || (mult_reg == 8'd0) || (byte_count[dbc_pkg::BLOCK_SHIFT-1:0] != '0)
                        || (rd_labelled && !part_ok);
        side.wr       = is_write;
        side.wlabel   = rd_wlabel;
        side.labelled = rd_labelled;
        side.soff     = rd_soff;
        side.endsec   = rd_labelled ? rd_psize : rd_ssize;
        side.poff     = rd_poff;
        side.lab      = rd_lab;
        side.count    = byte_count;
    end

    dbc_pkg::dbc_div_out_t div_res;

    dbc_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_load    (accept),
        .side_in    (side),
        .dividend_a (block_number[30:0]),
        .dividend_b (31'(byte_count[23:dbc_pkg::BLOCK_SHIFT])),
        .divisor    (mult_reg),
        .result     (div_res)
    );

    dbc_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .mult            (mult_reg),
        .div             (div_res),
        .out_valid       (out_valid),
        .status          (status),
        .physical_sector (physical_sector),
        .granted_bytes   (granted_bytes),
        .residual_bytes  (residual_bytes)
    );

    a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output backpressure");

    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(mult_reg))
        else $error("sector multiplier changed without a write");

    a_div_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(div_res.valid))
        else $error("divider advanced while stalled");

endmodule

`default_nettype wire
